FILE: sv/oae_pkg.sv
// ----------------------------------------------------------------------------
// oae_pkg
// Shared types and constants of the ordered array engine.
// ----------------------------------------------------------------------------
package oae_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int WORD_W    = 32;

    localparam int ACTION_W  = 3;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int FOUND_W   = 7;
    localparam int COUNT_W   = 8;

    localparam int IN_BITS   = ACTION_W + POS_W + WORD_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + FOUND_W + 2 * WORD_W + COUNT_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_MINMAX = 3'd3,
        ACT_UPDATE = 3'd4
    } action_t;

    localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MISS   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd4;

endpackage

FILE: sv/ordered_array_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_array_engine_top
// Ordered array of signed words with insert, delete, search, min/max and
// update, the entries held in one RAM.
//
//   Channel   Direction  Payload (lowest bit first)
//   s_axis    in         action[2:0], position[7:0], value[31:0]
//   m_axis    out        status[2:0], found_index[6:0], max_value[31:0],
//                        min_value[31:0], count[7:0]
//
// An insert or delete moves the entries from the given position onward,
// a search or min/max scans them from the first, a search stopping at its
// first hit, and an update writes its entry without a walk. The walk uses
// the single RAM read port, which reads the entries one per cycle, and the
// result appears as the input becomes ready.
// Reset clears the entry count only; the RAM contents are left as they are.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is accepted and processed, and the next
// result is held back until the receiver has taken the one before it.
// ----------------------------------------------------------------------------
module ordered_array_engine_top
    import oae_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action, position, value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, found_index, max, min, count
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                    state_reg;
    action_t                   action_reg;
    logic [ADDR_W-1:0]         pos_reg;
    logic [WORD_W-1:0]         value_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          remain_reg;
    logic [ADDR_W-1:0]         rd_addr_reg;
    logic                      pend_reg;
    logic [ADDR_W-1:0]         pend_addr_reg;
    logic                      hit_reg;
    logic [ADDR_W-1:0]         found_reg;
    logic signed [WORD_W-1:0]  max_reg;
    logic signed [WORD_W-1:0]  min_reg;
    logic                      final_wr_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    action_t                   in_action;
    logic [CMP_W-1:0]          in_pos;
    logic [CMP_W-1:0]          cnt_ext;
    logic [WORD_W-1:0]         in_value;
    logic                      accept;
    logic                      issue;
    logic                      walking;
    logic                      slot_free;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [WORD_W-1:0]         ram_wdata;
    logic [WORD_W-1:0]         ram_rdata;
    logic [STATUS_W-1:0]       res_status;
    logic [FOUND_W-1:0]        res_found;
    logic [WORD_W-1:0]         res_max;
    logic [WORD_W-1:0]         res_min;
    logic [CNT_W-1:0]          count_next;

    assign in_action = action_t'(s_tdata[ACTION_W-1:0]);
    assign in_pos    = CMP_W'(s_tdata[ACTION_W +: POS_W]);
    assign in_value  = s_tdata[ACTION_W+POS_W +: WORD_W];
    assign cnt_ext   = CMP_W'(count_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign walking   = (state_reg == S_SHIFT) || (state_reg == S_SCAN);
    assign issue     = walking && (remain_reg != '0) && !hit_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        if (state_reg == S_SHIFT && pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_FINISH && final_wr_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = value_reg;
        end
    end

    oae_ram
    #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        res_status = status_reg;
        res_found  = '0;
        res_max    = '0;
        res_min    = '0;
        count_next = count_reg;
        if (status_reg == STAT_OK)
        begin
            case (action_reg)
                ACT_INSERT: count_next = count_reg + 1'b1;
                ACT_DELETE: count_next = count_reg - 1'b1;
                ACT_MINMAX:
                begin
                    res_max = max_reg;
                    res_min = min_reg;
                end
                default: ;
            endcase
        end
        else if (status_reg == STAT_MISS && hit_reg)
        begin
            res_status = STAT_OK;
            res_found  = FOUND_W'(found_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            action_reg    <= ACT_INSERT;
            pos_reg       <= '0;
            value_reg     <= '0;
            status_reg    <= STAT_OK;
            count_reg     <= '0;
            remain_reg    <= '0;
            rd_addr_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            hit_reg       <= 1'b0;
            found_reg     <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            final_wr_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        action_reg   <= in_action;
                        pos_reg      <= ADDR_W'(in_pos);
                        value_reg    <= in_value;
                        hit_reg      <= 1'b0;
                        pend_reg     <= 1'b0;
                        final_wr_reg <= 1'b0;
                        status_reg   <= STAT_OK;
                        state_reg    <= S_FINISH;
                        case (in_action)
                            ACT_INSERT:
                            begin
                                if (in_pos > cnt_ext)
                                begin
                                    status_reg <= STAT_BADPOS;
                                end
                                else if (count_reg == CNT_W'(DEPTH))
                                begin
                                    status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    rd_addr_reg  <= ADDR_W'(count_reg - 1'b1);
                                    remain_reg   <= CNT_W'(cnt_ext - in_pos);
                                    final_wr_reg <= 1'b1;
                                    state_reg    <= S_SHIFT;
                                end
                            end
                            ACT_DELETE:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= STAT_EMPTY;
                                end
                                else if (in_pos >= cnt_ext)
                                begin
                                    status_reg <= STAT_BADPOS;
                                end
                                else
                                begin
                                    rd_addr_reg <= ADDR_W'(in_pos + 1'b1);
                                    remain_reg  <= CNT_W'(cnt_ext - in_pos - 1'b1);
                                    state_reg   <= S_SHIFT;
                                end
                            end
                            ACT_SEARCH, ACT_MINMAX:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= STAT_EMPTY;
                                end
                                else
                                begin
                                    if (in_action == ACT_SEARCH)
                                    begin
                                        status_reg <= STAT_MISS;
                                    end
                                    rd_addr_reg <= '0;
                                    remain_reg  <= count_reg;
                                    state_reg   <= S_SCAN;
                                end
                            end
                            ACT_UPDATE:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= STAT_EMPTY;
                                end
                                else if (in_pos >= cnt_ext)
                                begin
                                    status_reg <= STAT_BADPOS;
                                end
                                else
                                begin
                                    final_wr_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_SHIFT, S_SCAN:
                begin
                    pend_reg <= issue;
                    if (issue)
                    begin
                        remain_reg    <= remain_reg - 1'b1;
                        pend_addr_reg <= rd_addr_reg;
                        if (action_reg == ACT_INSERT)
                        begin
                            rd_addr_reg   <= rd_addr_reg - 1'b1;
                            pend_addr_reg <= rd_addr_reg + 1'b1;
                        end
                        else if (action_reg == ACT_DELETE)
                        begin
                            rd_addr_reg   <= rd_addr_reg + 1'b1;
                            pend_addr_reg <= rd_addr_reg - 1'b1;
                        end
                        else
                        begin
                            rd_addr_reg <= rd_addr_reg + 1'b1;
                        end
                    end
                    if (state_reg == S_SCAN && pend_reg && !hit_reg)
                    begin
                        if (action_reg == ACT_SEARCH)
                        begin
                            if (ram_rdata == value_reg)
                            begin
                                hit_reg   <= 1'b1;
                                found_reg <= pend_addr_reg;
                            end
                        end
                        else if (pend_addr_reg == '0)
                        begin
                            max_reg <= $signed(ram_rdata);
                            min_reg <= $signed(ram_rdata);
                        end
                        else
                        begin
                            if ($signed(ram_rdata) > max_reg)
                            begin
                                max_reg <= $signed(ram_rdata);
                            end
                            if ($signed(ram_rdata) < min_reg)
                            begin
                                min_reg <= $signed(ram_rdata);
                            end
                        end
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_W'({COUNT_W'(count_next), res_min, res_max,
                                                res_found, res_status});
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/oae_ram.sv
// ----------------------------------------------------------------------------
// oae_ram
// Generic RAM with one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module oae_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
